>>> sv/hbsf_pkg.sv
// ----------------------------------------------------------------------------
// hbsf_pkg
// shared constants and types of the byte-stuffing frame encoder
// ----------------------------------------------------------------------------
package hbsf_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_INIT  = 16'hFFFF;
  localparam logic [15:0] FCS_POLY  = 16'h8408;

  // one classified request handed from front to back
  typedef struct packed {
    logic        open;
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
  } hbsf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hbsf_qstat_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_OPEN,
    PH_DATA,
    PH_FCS_LO,
    PH_FCS_HI,
    PH_CLOSE
  } hbsf_phase_t;

endpackage

>>> sv/hdlc_byte_stuff_framer_fcs16.sv
// ----------------------------------------------------------------------------
// hdlc_byte_stuff_framer_fcs16
// async hdlc-like framer with byte stuffing and fcs-16
// ----------------------------------------------------------------------------
// The front stage takes one payload byte per cycle while the two-entry queue
// has room, updates the fcs-16 and queues the request; the back sequencer
// sends one line byte per cycle into the output register while the output is
// not stalled. Each request causes 1 or 2 line bytes for a plain byte, one
// more when it opens a frame, and 3 to 5 more when it closes one (up to 8 in
// all). The back sequencer's one byte per cycle sets the sustained rate.
module hdlc_byte_stuff_framer_fcs16 import hbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_line_byte,
  output logic       out_end_of_run,
  output logic       out_frame_done
);

  hbsf_job_t   push_job, head_job;
  hbsf_qstat_t q_stat;
  logic        push, pop;

  hbsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_job     (push_job)
  );

  hbsf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  hbsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_line_byte  (out_line_byte),
    .out_end_of_run (out_end_of_run),
    .out_frame_done (out_frame_done)
  );

endmodule

>>> sv/hbsf_front.sv
// ----------------------------------------------------------------------------
// hbsf_front
// accepts payload bytes, runs the fcs-16 and classifies each request
// ----------------------------------------------------------------------------
module hbsf_front import hbsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  hbsf_qstat_t q_stat,
  output logic        push,
  output hbsf_job_t   push_job
);

  logic [15:0] fcs_r, fcs_nxt;
  logic        open_r, open_nxt;
  logic [15:0] fcs_upd;

  function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] acc;
    acc = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ FCS_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign fcs_upd  = fcs_step(fcs_r, in_data_byte);

  always_comb begin
    fcs_nxt       = fcs_r;
    open_nxt      = open_r;
    push_job.open = !open_r;
    push_job.data = in_data_byte;
    push_job.last = in_last_byte;
    push_job.fcs  = ~fcs_upd;
    if (push) begin
      if (in_last_byte) begin
        fcs_nxt  = FCS_INIT;
        open_nxt = 1'b0;
      end else begin
        fcs_nxt  = fcs_upd;
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_r  <= FCS_INIT;
      open_r <= 1'b0;
    end else begin
      fcs_r  <= fcs_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

>>> sv/hbsf_queue.sv
// ----------------------------------------------------------------------------
// hbsf_queue
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module hbsf_queue import hbsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  hbsf_job_t   push_job,
  input  logic        pop,
  output hbsf_job_t   head_job,
  output hbsf_qstat_t q_stat
);

  hbsf_job_t   mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push, do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/hbsf_back.sv
// ----------------------------------------------------------------------------
// hbsf_back
// byte sequencer: flags, escaping and fcs bytes into the output register
// ----------------------------------------------------------------------------
module hbsf_back import hbsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  hbsf_job_t   head_job,
  input  hbsf_qstat_t q_stat,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_line_byte,
  output logic        out_end_of_run,
  output logic        out_frame_done
);

  hbsf_phase_t phase_r, phase_nxt;
  hbsf_phase_t eff_phase, adv_phase;
  logic        esc_r, esc_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        eor_r, eor_nxt;
  logic        done_r, done_nxt;
  logic [7:0]  cur_byte;
  logic        escapable, special, step, final_byte;

  assign eff_phase = (phase_r == PH_START) ? (head_job.open ? PH_OPEN : PH_DATA) : phase_r;
  assign step      = !q_stat.empty && (!vld_r || out_ready);

  always_comb begin
    cur_byte   = FLAG_BYTE;
    escapable  = 1'b1;
    adv_phase  = PH_START;
    final_byte = 1'b0;
    case (eff_phase)
      PH_OPEN: begin
        escapable = 1'b0;
        adv_phase = PH_DATA;
      end
      PH_DATA: begin
        cur_byte   = head_job.data;
        adv_phase  = head_job.last ? PH_FCS_LO : PH_START;
        final_byte = !head_job.last;
      end
      PH_FCS_LO: begin
        cur_byte  = head_job.fcs[7:0];
        adv_phase = PH_FCS_HI;
      end
      PH_FCS_HI: begin
        cur_byte  = head_job.fcs[15:8];
        adv_phase = PH_CLOSE;
      end
      PH_CLOSE: begin
        escapable  = 1'b0;
        final_byte = 1'b1;
      end
      default: begin
        escapable = 1'b0;
      end
    endcase
    special = cur_byte inside {FLAG_BYTE, ESC_BYTE};
  end

  always_comb begin
    phase_nxt = phase_r;
    esc_nxt   = esc_r;
    pop       = 1'b0;
    vld_nxt   = out_ready ? 1'b0 : vld_r;
    byte_nxt  = byte_r;
    eor_nxt   = eor_r;
    done_nxt  = done_r;
    if (step) begin
      vld_nxt  = 1'b1;
      done_nxt = 1'b0;
      eor_nxt  = 1'b0;
      if (escapable && special && !esc_r) begin
        byte_nxt  = ESC_BYTE;
        esc_nxt   = 1'b1;
        phase_nxt = eff_phase;
      end else begin
        byte_nxt  = esc_r ? (cur_byte ^ ESC_XOR) : cur_byte;
        esc_nxt   = 1'b0;
        phase_nxt = adv_phase;
        done_nxt  = (eff_phase == PH_CLOSE);
        eor_nxt   = final_byte;
        pop       = final_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      esc_r   <= 1'b0;
      vld_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      esc_r   <= esc_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    eor_r  <= eor_nxt;
    done_r <= done_nxt;
  end

  assign out_valid      = vld_r;
  assign out_line_byte  = byte_r;
  assign out_end_of_run = eor_r;
  assign out_frame_done = done_r;

endmodule

>>> bench/hbsf_checker.sv
// ----------------------------------------------------------------------------
// hbsf_checker
// watches both channels of the framer, predicts the line bytes of every
// accepted request and compares each line byte, field by field, in order
// ----------------------------------------------------------------------------
module hbsf_checker import hbsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_line_byte,
  input  logic       out_end_of_run,
  input  logic       out_frame_done,
  output int         fail_count,
  output int         line_pending,
  output int         requests_seen,
  output int         frames_closed,
  output int         stuffed_bytes
);

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_run;
    logic       frame_done;
  } line_sym_t;

  line_sym_t   line_q[$];
  line_sym_t   run_buf[8];
  int          run_len;
  line_sym_t   want;
  logic [15:0] fcs_acc;
  logic        open_frame;
  int          lines_seen;

  function automatic logic [15:0] fcs16_next(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] acc;
    acc = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) acc = (acc >> 1) ^ FCS_POLY;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

  task automatic append(input logic [7:0] b, input logic done);
    run_buf[run_len] = '{line_byte: b, end_of_run: 1'b0, frame_done: done};
    run_len++;
  endtask

  task automatic append_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE || b == ESC_BYTE) begin
      append(ESC_BYTE, 1'b0);
      append(b ^ ESC_XOR, 1'b0);
      stuffed_bytes++;
    end else begin
      append(b, 1'b0);
    end
  endtask

  task automatic predict_request(input logic [7:0] b, input logic last);
    logic [15:0] fin;
    run_len = 0;
    if (!open_frame) begin
      append(FLAG_BYTE, 1'b0);
      open_frame = 1'b1;
    end
    append_stuffed(b);
    fcs_acc = fcs16_next(fcs_acc, b);
    if (last) begin
      fin = ~fcs_acc;
      append_stuffed(fin[7:0]);
      append_stuffed(fin[15:8]);
      append(FLAG_BYTE, 1'b1);
      fcs_acc = FCS_INIT;
      open_frame = 1'b0;
    end
    run_buf[run_len-1].end_of_run = 1'b1;
    for (int i = 0; i < run_len; i++) line_q.push_back(run_buf[i]);
  endtask

  task automatic report(input string what, input int got, input int exp_val);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("mismatch on line byte %0d (after request %0d): %s got %0h want %0h",
               lines_seen, requests_seen, what, got, exp_val);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      line_q.delete();
      fcs_acc = FCS_INIT;
      open_frame = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request(in_data_byte, in_last_byte);
        requests_seen++;
      end
      if (out_valid && out_ready) begin
        if (line_q.size() == 0) begin
          report("line byte with nothing outstanding", out_line_byte, 0);
        end else begin
          want = line_q.pop_front();
          if (out_line_byte !== want.line_byte)
            report("line_byte", out_line_byte, want.line_byte);
          if (out_end_of_run !== want.end_of_run)
            report("end_of_run", out_end_of_run, want.end_of_run);
          if (out_frame_done !== want.frame_done)
            report("frame_done", out_frame_done, want.frame_done);
          if (want.frame_done) frames_closed++;
        end
        lines_seen++;
      end
    end
    line_pending <= line_q.size();
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the hdlc byte-stuffing framer with fcs-16
// ----------------------------------------------------------------------------
// Drives payload bytes in frames of mostly short random length, with flag and
// escape values favoured, after a directed set of escape and fcs corner cases.
// Both sides idle at random; long output stalls back the block up, one
// stretch runs without idling, and the sender drains the block mid-run.
// hbsf_checker predicts and compares every line byte.
// ----------------------------------------------------------------------------
module tb import hbsf_pkg::*; ();

  localparam int CYCLE_LIMIT  = 250000;
  localparam int HOLD_CYCLES  = 120;
  localparam int RANDOM_ITEMS = 410;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_line_byte;
  logic       out_end_of_run;
  logic       out_frame_done;

  int fail_count;
  int line_pending;
  int requests_seen;
  int frames_closed;
  int stuffed_bytes;
  int cycles = 0;
  int sent = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  hdlc_byte_stuff_framer_fcs16 DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_byte (out_line_byte),
    .out_end_of_run(out_end_of_run),
    .out_frame_done(out_frame_done)
  );

  hbsf_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_last_byte  (in_last_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_line_byte (out_line_byte),
    .out_end_of_run(out_end_of_run),
    .out_frame_done(out_frame_done),
    .fail_count    (fail_count),
    .line_pending  (line_pending),
    .requests_seen (requests_seen),
    .frames_closed (frames_closed),
    .stuffed_bytes (stuffed_bytes)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes outstanding", cycles, line_pending);
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (line_pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return FLAG_BYTE;
      1:       return ESC_BYTE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  // output side: random stalls, one long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int len;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte frames at the data extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // data needing stuffing, neighbours that must not be stuffed
    send_byte(FLAG_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b0);
    send_byte(8'h5E, 1'b0);
    send_byte(8'h5D, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    // single-byte frames whose fcs bytes need stuffing
    send_byte(8'hF1, 1'b1);
    send_byte(8'h19, 1'b1);
    send_byte(8'h2A, 1'b1);
    // flag and escape values as whole frames and at frame start
    send_byte(FLAG_BYTE, 1'b1);
    send_byte(ESC_BYTE, 1'b1);
    send_byte(FLAG_BYTE, 1'b0);
    send_byte(FLAG_BYTE, 1'b0);
    send_byte(ESC_BYTE, 1'b1);
    drain_block();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(5, 1);
      if (sent >= 120 && sent < 130) drain_block();
      if (sent >= 200 && sent < 210) hold_req = 1'b1;
      calm = (sent >= 260 && sent < 330);
      send_frame(len);
    end
    calm = 1'b0;
    drain_block();
    repeat (30) @(posedge clk);

    $display("covered %0d requests in %0d frames, %0d stuffed bytes, single-byte frames,",
             requests_seen, frames_closed, stuffed_bytes);
    $display("a long output stall, an idle-free stretch and a mid-run drain");
    if (fail_count == 0 && line_pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule

>>> hdlc_byte_stuff_framer_fcs16.f
sv/hbsf_pkg.sv
sv/hbsf_front.sv
sv/hbsf_queue.sv
sv/hbsf_back.sv
sv/hdlc_byte_stuff_framer_fcs16.sv
bench/hbsf_checker.sv
bench/tb.sv
